// ===== rtl/core/min_max_penalty_job_order_macros.svh =====
// assertion macros for the min-max penalty job order block
// used by the top level only; no other dependencies
`ifndef MIN_MAX_PENALTY_JOB_ORDER_MACROS_SVH
`define MIN_MAX_PENALTY_JOB_ORDER_MACROS_SVH

`ifndef SYNTHESIS
`define MMP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MMP_ASSERT_IMPL(lbl, ante, cons)
`define MMP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/mmp_pkg.sv =====
// shared types and constants of the min-max penalty job order block
// no dependencies
package mmp_pkg;

  localparam int LEN_W  = 17;
  localparam int COEF_W = 10;
  localparam int T_W    = 19;
  localparam int PEN_W  = 60;
  localparam int BND_W  = 63;
  localparam int IDX_W  = 6;
  localparam logic [T_W-1:0] TIME_LIMIT = 19'd100000;
  localparam logic [5:0] TOP_BIT = 6'd62;
  localparam logic [4:0] SEARCH_TOP = 5'd16;

  typedef struct packed {
    logic [COEF_W-1:0] c0;
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c3;
  } coef_t;

  typedef struct packed {
    logic             done;
    logic             inf;
    logic [PEN_W-1:0] value;
  } pen_res_t;

endpackage

// ===== rtl/core/mmp_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module mmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/core/mmp_pen.sv =====
// cubic penalty evaluator, horner form on a split multiplier
// depends on mmp_pkg
module mmp_pen (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mmp_pkg::T_W-1:0]      t,
  input  mmp_pkg::coef_t               coef,
  output mmp_pkg::pen_res_t            res
);
  import mmp_pkg::*;

  logic             busy_r, busy_nxt;
  logic             ph_r, ph_nxt;
  logic [1:0]       stp_r, stp_nxt;
  logic             done_r, done_nxt;
  logic             inf_r, inf_nxt;
  logic [LEN_W-1:0] t_r, t_nxt;
  coef_t            cf_r, cf_nxt;
  logic [PEN_W-1:0] acc_r, acc_nxt;
  logic [38:0]      lo_r, lo_nxt, hi_r, hi_nxt;
  logic [COEF_W-1:0] addc;

  always_comb begin
    unique case (stp_r)
      2'd0:    addc = cf_r.c2;
      2'd1:    addc = cf_r.c1;
      default: addc = cf_r.c0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    stp_nxt  = stp_r;
    done_nxt = 1'b0;
    inf_nxt  = inf_r;
    t_nxt    = t_r;
    cf_nxt   = cf_r;
    acc_nxt  = acc_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    if (start) begin
      if (t > TIME_LIMIT) begin
        done_nxt = 1'b1;
        inf_nxt  = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b1;
        inf_nxt  = 1'b0;
        ph_nxt   = 1'b0;
        stp_nxt  = 2'd0;
        t_nxt    = t[LEN_W-1:0];
        cf_nxt   = coef;
        acc_nxt  = PEN_W'(coef.c3);
      end
    end else if (busy_r) begin
      if (!ph_r) begin
        // acc stays below 2^44 before each multiply
        lo_nxt = acc_r[21:0] * t_r;
        hi_nxt = acc_r[43:22] * t_r;
        ph_nxt = 1'b1;
      end else begin
        acc_nxt = PEN_W'({hi_r, 22'b0} + 61'(lo_r) + 61'(addc));
        ph_nxt  = 1'b0;
        if (stp_r == 2'd2) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          stp_nxt = stp_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 1'b0;
      stp_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ph_r   <= ph_nxt;
      stp_r  <= stp_nxt;
    end
    inf_r <= inf_nxt;
    t_r   <= t_nxt;
    cf_r  <= cf_nxt;
    acc_r <= acc_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
  end

  assign res.done  = done_r;
  assign res.inf   = inf_r;
  assign res.value = acc_r;
endmodule

// ===== rtl/core/min_max_penalty_job_order.sv =====
// Min-max penalty job order. Jobs are loaded one word each; the word with
// last_job set starts the solve over the stored jobs (words beyond MAX_JOBS
// are dropped). The solve runs 63 trial bounds, bit 62 down. Each trial runs
// the deadline searches on the penalty evaluator, ranks the deadlines through
// the deadline ram port and then makes the feasibility pass. The block takes
// no new job word until the last result of the run has been taken, and it
// holds each result until it is taken before it reads the next one.
// Depends on mmp_pkg, mmp_ram, mmp_pen and the assertion macro header.
`include "min_max_penalty_job_order_macros.svh"
module min_max_penalty_job_order #(
  parameter int MAX_JOBS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mmp_pkg::LEN_W-1:0]      in_job_length,
  input  logic [mmp_pkg::COEF_W-1:0]     in_coef_const,
  input  logic [mmp_pkg::COEF_W-1:0]     in_coef_linear,
  input  logic [mmp_pkg::COEF_W-1:0]     in_coef_square,
  input  logic [mmp_pkg::COEF_W-1:0]     in_coef_cube,
  input  logic                           in_last_job,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mmp_pkg::IDX_W-1:0]      out_job_index,
  output logic                           out_last_result,
  output logic                           out_no_schedule
);
  import mmp_pkg::*;

  localparam int IW   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNTW = $clog2(MAX_JOBS + 1);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_TRIAL    = 5'd1;
  localparam logic [4:0] S_LEN_RD   = 5'd2;
  localparam logic [4:0] S_LEN_EVAL = 5'd3;
  localparam logic [4:0] S_LEN_WAIT = 5'd4;
  localparam logic [4:0] S_SRCH     = 5'd5;
  localparam logic [4:0] S_SRCH_WT  = 5'd6;
  localparam logic [4:0] S_RK_RDI   = 5'd7;
  localparam logic [4:0] S_RK_LATI  = 5'd8;
  localparam logic [4:0] S_RK_RDJ   = 5'd9;
  localparam logic [4:0] S_RK_CMP   = 5'd10;
  localparam logic [4:0] S_RK_WR    = 5'd11;
  localparam logic [4:0] S_CK_ORD   = 5'd12;
  localparam logic [4:0] S_CK_JRD   = 5'd13;
  localparam logic [4:0] S_CK_EVAL  = 5'd14;
  localparam logic [4:0] S_CK_WAIT  = 5'd15;
  localparam logic [4:0] S_TEND     = 5'd16;
  localparam logic [4:0] S_OUT_RD   = 5'd17;
  localparam logic [4:0] S_OUT_SET  = 5'd18;
  localparam logic [4:0] S_OUT_WAIT = 5'd19;

  logic [4:0]       state_r, state_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt, n_r, n_nxt;
  logic [IW-1:0]    i_r, i_nxt, j_r, j_nxt, rank_r, rank_nxt, last_idx;
  logic [BND_W-1:0] bound_r, bound_nxt, v_r, v_nxt;
  logic             found_r, found_nxt, tb_r, tb_nxt, ok_r, ok_nxt;
  logic [5:0]       bit_r, bit_nxt;
  logic [LEN_W-1:0] len_r, len_nxt, slack_r, slack_nxt, di_r, di_nxt;
  logic [4:0]       sb_r, sb_nxt;
  logic [17:0]      cur_r, cur_nxt, cur_sum;
  coef_t            coef_r, coef_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic             out_last_r, out_last_nxt, out_nos_r, out_nos_nxt;

  logic             in_acc;
  logic             len_we;
  logic [IW-1:0]    len_raddr;
  logic [LEN_W-1:0] len_rd;
  coef_t            coef_wr, coef_rd;
  logic             dl_we;
  logic [IW-1:0]    dl_raddr;
  logic [LEN_W-1:0] dl_wdata, dl_rd;
  logic             ord_we;
  logic [IW:0]      ord_raddr;
  logic [IDX_W-1:0] ord_rd;

  logic             ev_start;
  logic [T_W-1:0]   ev_t, step;
  coef_t            ev_coef;
  pen_res_t         ev_res;
  logic             pen_ok;
  logic [LEN_W-1:0] slack_new;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign last_idx = IW'(n_r - CNTW'(1));
  assign step     = T_W'(1) << sb_r;
  assign pen_ok   = !ev_res.inf && ({3'b0, ev_res.value} <= v_r);
  assign slack_new = pen_ok ? (slack_r | step[LEN_W-1:0]) : slack_r;
  assign cur_sum  = cur_r + 18'(len_rd);

  assign coef_wr.c0 = in_coef_const;
  assign coef_wr.c1 = in_coef_linear;
  assign coef_wr.c2 = in_coef_square;
  assign coef_wr.c3 = in_coef_cube;

  assign len_we    = in_acc && (cnt_r < CNTW'(MAX_JOBS));
  assign len_raddr = (state_r == S_CK_JRD) ? ord_rd[IW-1:0] : i_r;
  assign dl_we     = (state_r == S_SRCH_WT) && ev_res.done && (sb_r == 5'd0);
  assign dl_wdata  = LEN_W'(slack_new + len_r);
  assign dl_raddr  = (state_r == S_RK_RDI) ? i_r : j_r;
  assign ord_we    = (state_r == S_RK_WR);
  assign ord_raddr = (state_r == S_OUT_RD) ? {~tb_r, i_r} : {tb_r, i_r};

  always_comb begin
    ev_start = 1'b0;
    ev_t     = T_W'(len_rd);
    ev_coef  = coef_rd;
    unique case (state_r)
      S_LEN_EVAL: ev_start = 1'b1;
      S_SRCH: begin
        ev_start = 1'b1;
        ev_t     = T_W'(slack_r) + T_W'(len_r) + step;
        ev_coef  = coef_r;
      end
      S_CK_EVAL: begin
        ev_start = 1'b1;
        ev_t     = T_W'(cur_sum);
      end
      default: ev_start = 1'b0;
    endcase
  end

  mmp_ram #(.WIDTH(LEN_W), .DEPTH(MAX_JOBS)) u_len_ram (
    .clk(clk), .we(len_we), .waddr(cnt_r[IW-1:0]), .wdata(in_job_length),
    .raddr(len_raddr), .rdata(len_rd)
  );

  mmp_ram #(.WIDTH($bits(coef_t)), .DEPTH(MAX_JOBS)) u_coef_ram (
    .clk(clk), .we(len_we), .waddr(cnt_r[IW-1:0]), .wdata(coef_wr),
    .raddr(len_raddr), .rdata(coef_rd)
  );

  mmp_ram #(.WIDTH(LEN_W), .DEPTH(MAX_JOBS)) u_dl_ram (
    .clk(clk), .we(dl_we), .waddr(i_r), .wdata(dl_wdata),
    .raddr(dl_raddr), .rdata(dl_rd)
  );

  // two banks: one holds the best order, the other takes the current trial
  mmp_ram #(.WIDTH(IDX_W), .DEPTH(2 ** (IW + 1))) u_ord_ram (
    .clk(clk), .we(ord_we), .waddr({tb_r, rank_r}), .wdata(IDX_W'(i_r)),
    .raddr(ord_raddr), .rdata(ord_rd)
  );

  mmp_pen u_pen (
    .clk(clk), .rst_n(rst_n), .start(ev_start), .t(ev_t), .coef(ev_coef),
    .res(ev_res)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rank_nxt      = rank_r;
    bound_nxt     = bound_r;
    v_nxt         = v_r;
    found_nxt     = found_r;
    tb_nxt        = tb_r;
    ok_nxt        = ok_r;
    bit_nxt       = bit_r;
    len_nxt       = len_r;
    slack_nxt     = slack_r;
    di_nxt        = di_r;
    sb_nxt        = sb_r;
    cur_nxt       = cur_r;
    coef_nxt      = coef_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    out_nos_nxt   = out_nos_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (len_we) begin
            cnt_nxt = cnt_r + CNTW'(1);
          end
          if (in_last_job) begin
            n_nxt     = len_we ? cnt_r + CNTW'(1) : cnt_r;
            cnt_nxt   = '0;
            bound_nxt = '1;
            found_nxt = 1'b0;
            bit_nxt   = TOP_BIT;
            i_nxt     = '0;
            if (len_we || (cnt_r != '0)) begin
              state_nxt = S_TRIAL;
            end else begin
              state_nxt = S_OUT_RD;
            end
          end
        end
      end
      S_TRIAL: begin
        v_nxt     = bound_r - (BND_W'(1) << bit_r);
        i_nxt     = '0;
        state_nxt = S_LEN_RD;
      end
      S_LEN_RD: state_nxt = S_LEN_EVAL;
      S_LEN_EVAL: begin
        len_nxt   = len_rd;
        coef_nxt  = coef_rd;
        state_nxt = S_LEN_WAIT;
      end
      S_LEN_WAIT: begin
        if (ev_res.done) begin
          if (!pen_ok) begin
            ok_nxt    = 1'b0;
            state_nxt = S_TEND;
          end else begin
            slack_nxt = '0;
            sb_nxt    = SEARCH_TOP;
            state_nxt = S_SRCH;
          end
        end
      end
      S_SRCH: state_nxt = S_SRCH_WT;
      S_SRCH_WT: begin
        if (ev_res.done) begin
          slack_nxt = slack_new;
          if (sb_r == 5'd0) begin
            if (i_r == last_idx) begin
              i_nxt     = '0;
              state_nxt = S_RK_RDI;
            end else begin
              i_nxt     = i_r + IW'(1);
              state_nxt = S_LEN_RD;
            end
          end else begin
            sb_nxt    = sb_r - 5'd1;
            state_nxt = S_SRCH;
          end
        end
      end
      S_RK_RDI: state_nxt = S_RK_LATI;
      S_RK_LATI: begin
        di_nxt    = dl_rd;
        j_nxt     = '0;
        rank_nxt  = '0;
        state_nxt = S_RK_RDJ;
      end
      S_RK_RDJ: state_nxt = S_RK_CMP;
      S_RK_CMP: begin
        // stable rank: earlier deadlines, then equal deadlines at lower index
        if ((dl_rd < di_r) || ((dl_rd == di_r) && (j_r < i_r))) begin
          rank_nxt = rank_r + IW'(1);
        end
        if (j_r == last_idx) begin
          state_nxt = S_RK_WR;
        end else begin
          j_nxt     = j_r + IW'(1);
          state_nxt = S_RK_RDJ;
        end
      end
      S_RK_WR: begin
        if (i_r == last_idx) begin
          i_nxt     = '0;
          cur_nxt   = '0;
          state_nxt = S_CK_ORD;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = S_RK_RDI;
        end
      end
      S_CK_ORD: state_nxt = S_CK_JRD;
      S_CK_JRD: state_nxt = S_CK_EVAL;
      S_CK_EVAL: begin
        cur_nxt   = cur_sum;
        state_nxt = S_CK_WAIT;
      end
      S_CK_WAIT: begin
        if (ev_res.done) begin
          if (!pen_ok) begin
            ok_nxt    = 1'b0;
            state_nxt = S_TEND;
          end else if (i_r == last_idx) begin
            ok_nxt    = 1'b1;
            state_nxt = S_TEND;
          end else begin
            i_nxt     = i_r + IW'(1);
            state_nxt = S_CK_ORD;
          end
        end
      end
      S_TEND: begin
        if (ok_r) begin
          bound_nxt = v_r;
          found_nxt = 1'b1;
          tb_nxt    = ~tb_r;
        end
        if (bit_r == 6'd0) begin
          i_nxt     = '0;
          state_nxt = S_OUT_RD;
        end else begin
          bit_nxt   = bit_r - 6'd1;
          state_nxt = S_TRIAL;
        end
      end
      S_OUT_RD: state_nxt = S_OUT_SET;
      S_OUT_SET: begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = found_r ? ord_rd : '0;
        out_last_nxt  = !found_r || (i_r == last_idx);
        out_nos_nxt   = !found_r;
        state_nxt     = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + IW'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      bound_r     <= '1;
      found_r     <= 1'b0;
      tb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bound_r     <= bound_nxt;
      found_r     <= found_nxt;
      tb_r        <= tb_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    rank_r     <= rank_nxt;
    v_r        <= v_nxt;
    ok_r       <= ok_nxt;
    bit_r      <= bit_nxt;
    len_r      <= len_nxt;
    slack_r    <= slack_nxt;
    di_r       <= di_nxt;
    sb_r       <= sb_nxt;
    cur_r      <= cur_nxt;
    coef_r     <= coef_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
    out_nos_r  <= out_nos_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_job_index   = out_idx_r;
  assign out_last_result = out_last_r;
  assign out_no_schedule = out_nos_r;

  `MMP_ASSERT_IMPL(a_no_load_during_out, in_valid && !in_stall, !out_valid)
  `MMP_ASSERT_IMPL(a_nosched_is_last, out_valid && out_no_schedule, out_last_result)
  `MMP_ASSERT_IMPL(a_count_in_range, state_r == S_IDLE, cnt_r <= CNTW'(MAX_JOBS))
  `MMP_ASSERT_NEXT(a_trial_bit_steps, state_r == S_TEND && bit_r != 6'd0,
                   state_r == S_TRIAL)
endmodule

// ===== verif/tb.sv =====
// self-checking testbench for min_max_penalty_job_order
// drives job sets and checks every result word against an in-bench scheduler,
// or against the hand-read result of a typed row; depends on mmp_pkg and the block's RTL
`timescale 1ns / 100ps
module tb;
  import mmp_pkg::*;

  localparam int MAX_JOBS = 16;
  localparam int IDLE_LIMIT = 1000000;
  localparam logic [63:0] INF_PEN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] T_MAX = 64'd100000;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             ns;
  } order_word_t;

  // directed job words; typed rows carry a hand-read result
  typedef struct {
    logic [LEN_W-1:0]  len;
    logic [COEF_W-1:0] c0, c1, c2, c3;
    logic              last;
    logic              typed;
    logic              ns;
  } job_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_last_job;
  logic [LEN_W-1:0] in_job_length;
  logic [COEF_W-1:0] in_coef_const, in_coef_linear, in_coef_square, in_coef_cube;
  logic out_valid, out_stall, out_last_result, out_no_schedule;
  logic [IDX_W-1:0] out_job_index;

  logic row_typed, row_ns, in_took, calm;
  int errors, words_sent, sets_solved, results_seen, idle_cycles, stall_left;

  logic [LEN_W-1:0]  job_len [MAX_JOBS];
  logic [COEF_W-1:0] job_coef [MAX_JOBS][4];
  int job_cnt;
  order_word_t order_q[$];

  min_max_penalty_job_order #(.MAX_JOBS(MAX_JOBS)) DUT (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] cost_at(int j, logic [63:0] t);
    logic [63:0] c0, c1, c2, c3;
    c0 = job_coef[j][0]; c1 = job_coef[j][1];
    c2 = job_coef[j][2]; c3 = job_coef[j][3];
    if (t > T_MAX) return INF_PEN;
    return c0 + c1 * t + c2 * t * t + c3 * t * t * t;
  endfunction

  function automatic bit fits_bound(logic [63:0] v, ref int ord[MAX_JOBS]);
    logic [16:0] dl [MAX_JOBS];
    logic [63:0] slack, span;
    int k;
    span = 0;
    for (int i = 0; i < job_cnt; i++) begin
      if (cost_at(i, job_len[i]) > v) return 0;
      slack = 0;
      for (int b = 16; b >= 0; b--)
        if (cost_at(i, slack + job_len[i] + (64'd1 << b)) <= v) slack += 64'd1 << b;
      dl[i] = 17'(slack + job_len[i]);
      k = i;
      while (k > 0 && dl[ord[k-1]] > dl[i]) begin
        ord[k] = ord[k-1];
        k--;
      end
      ord[k] = i;
    end
    for (int i = 0; i < job_cnt; i++) begin
      span += job_len[ord[i]];
      if (cost_at(ord[i], span) > v) return 0;
    end
    return 1;
  endfunction

  // append one expected word at the tail of the queue
  function automatic void add_expected(order_word_t w);
    order_q = {order_q, w};
  endfunction

  // store the word; on the last word search the min-max bound and queue the order
  task automatic schedule_word(logic [LEN_W-1:0] len, logic [COEF_W-1:0] c0, c1, c2, c3,
                               logic last, logic typed, logic ns);
    int ord[MAX_JOBS];
    int best[MAX_JOBS];
    logic [63:0] bound, v;
    bit found;
    order_word_t w;
    if (job_cnt < MAX_JOBS) begin
      job_len[job_cnt] = len;
      job_coef[job_cnt][0] = c0; job_coef[job_cnt][1] = c1;
      job_coef[job_cnt][2] = c2; job_coef[job_cnt][3] = c3;
      job_cnt++;
    end
    if (!last) return;
    bound = INF_PEN - 1;
    found = 0;
    for (int b = 62; b >= 0; b--) begin
      v = bound - (64'd1 << b);
      if (fits_bound(v, ord)) begin
        best = ord;
        bound = v;
        found = 1;
      end
    end
    sets_solved++;
    if (typed) begin
      w.idx = 0; w.last = 1; w.ns = ns;
      add_expected(w);
    end else if (!found || job_cnt == 0) begin
      w.idx = 0; w.last = 1; w.ns = 1;
      add_expected(w);
    end else begin
      for (int k = 0; k < job_cnt; k++) begin
        w.idx = IDX_W'(best[k]); w.last = (k + 1 == job_cnt); w.ns = 0;
        add_expected(w);
      end
    end
    job_cnt = 0;
  endtask

  // acceptance, checking and watchdog, all at the rising edge
  always @(posedge clk) begin
    order_word_t exp_w;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && !in_stall) begin
        idle_cycles = 0;
        schedule_word(in_job_length, in_coef_const, in_coef_linear, in_coef_square,
                      in_coef_cube, in_last_job, row_typed, row_ns);
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        results_seen++;
        if (order_q.size() == 0) begin
          $display("%0t: unexpected word idx=%0d last=%0b ns=%0b", $realtime,
                   out_job_index, out_last_result, out_no_schedule);
          errors++;
        end else begin
          exp_w = order_q.pop_front();
          if (out_job_index !== exp_w.idx) begin
            $display("%0t: job_index exp %0d got %0d", $realtime, exp_w.idx, out_job_index);
            errors++;
          end
          if (out_last_result !== exp_w.last) begin
            $display("%0t: last_result exp %0b got %0b", $realtime, exp_w.last,
                     out_last_result);
            errors++;
          end
          if (out_no_schedule !== exp_w.ns) begin
            $display("%0t: no_schedule exp %0b got %0b", $realtime, exp_w.ns,
                     out_no_schedule);
            errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired, %0d words pending", $realtime, order_q.size());
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(0, 2);
    if (r < 18) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // result side stall runs of random length, with calm stretches of no stall
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall = 0;
      stall_left = 0;
    end else begin
      if ($urandom_range(0, 299) == 0) calm = ~calm;
      if (stall_left > 0) stall_left--;
      else if (!calm && $urandom_range(0, 3) == 0) stall_left = gap_len();
      out_stall = (stall_left > 0);
    end
  end

  task automatic send_word(logic [LEN_W-1:0] len, logic [COEF_W-1:0] c0, c1, c2, c3,
                           logic last, logic typed, logic ns);
    int g;
    g = calm ? 0 : gap_len();
    if (g > 0) begin
      in_valid = 0;
      repeat (g) @(negedge clk);
    end
    in_job_length = len;
    in_coef_const = c0; in_coef_linear = c1; in_coef_square = c2; in_coef_cube = c3;
    in_last_job = last;
    row_typed = typed; row_ns = ns;
    in_valid = 1;
    do @(negedge clk); while (!in_took);
    words_sent++;
  endtask

  task automatic send_random_set();
    int r, n;
    logic [LEN_W-1:0] len;
    logic [COEF_W-1:0] c [4];
    r = $urandom_range(0, 99);
    if (r < 80) n = $urandom_range(1, 4);
    else if (r < 95) n = $urandom_range(5, 8);
    else n = $urandom_range(16, 18);
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < 65) len = LEN_W'($urandom_range(0, 2000));
      else if (r < 94) len = LEN_W'($urandom_range(0, 100000));
      else len = LEN_W'($urandom_range(100001, 131071));
      for (int q = 0; q < 4; q++)
        c[q] = ($urandom_range(0, 1) == 1) ? COEF_W'($urandom_range(0, 1023))
                                            : COEF_W'($urandom_range(0, 15));
      send_word(len, c[0], c[1], c[2], c[3], j == n - 1, 1'b0, 1'b0);
    end
  endtask

  job_row_t dir_rows[$] = '{
    '{17'd0,      10'd0,    10'd0,    10'd0,    10'd0,    1'b1, 1'b1, 1'b0},
    '{17'd100000, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b1, 1'b0},
    '{17'd100001, 10'd0,    10'd0,    10'd0,    10'd0,    1'b1, 1'b1, 1'b1},
    '{17'd131071, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b1, 1'b1},
    '{17'd10,     10'd5,    10'd300,  10'd1,    10'd0,    1'b0, 1'b0, 1'b0},
    '{17'd20,     10'd900,  10'd2,    10'd0,    10'd7,    1'b0, 1'b0, 1'b0},
    '{17'd30,     10'd0,    10'd0,    10'd1023, 10'd1,    1'b1, 1'b0, 1'b0},
    '{17'd500,    10'd3,    10'd3,    10'd3,    10'd3,    1'b0, 1'b0, 1'b0},
    '{17'd500,    10'd3,    10'd3,    10'd3,    10'd3,    1'b1, 1'b0, 1'b0},
    '{17'd60000,  10'd1,    10'd0,    10'd0,    10'd0,    1'b0, 1'b0, 1'b0},
    '{17'd50000,  10'd1,    10'd0,    10'd0,    10'd0,    1'b1, 1'b1, 1'b1},
    '{17'd65535,  10'd512,  10'd256,  10'd0,    10'd0,    1'b0, 1'b0, 1'b0},
    '{17'd34465,  10'd0,    10'd0,    10'd0,    10'd1023, 1'b1, 1'b0, 1'b0},
    '{17'd1,      10'd1023, 10'd0,    10'd0,    10'd0,    1'b0, 1'b0, 1'b0},
    '{17'd2,      10'd0,    10'd1023, 10'd0,    10'd0,    1'b0, 1'b0, 1'b0},
    '{17'd4,      10'd0,    10'd0,    10'd1023, 10'd0,    1'b0, 1'b0, 1'b0},
    '{17'd8,      10'd0,    10'd0,    10'd0,    10'd1023, 1'b1, 1'b0, 1'b0}
  };

  initial begin
    rst_n = 0; in_valid = 0; out_stall = 0; calm = 0; in_took = 0;
    in_job_length = 0; in_coef_const = 0; in_coef_linear = 0;
    in_coef_square = 0; in_coef_cube = 0; in_last_job = 0;
    row_typed = 0; row_ns = 0;
    errors = 0; words_sent = 0; sets_solved = 0; results_seen = 0; idle_cycles = 0;
    stall_left = 0;
    job_cnt = 0;
    repeat (3) @(negedge clk);
    rst_n = 1;
    foreach (dir_rows[i])
      send_word(dir_rows[i].len, dir_rows[i].c0, dir_rows[i].c1, dir_rows[i].c2,
                dir_rows[i].c3, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].ns);
    while (words_sent < 140) send_random_set();
    in_valid = 0;
    while (order_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("tb: %0d job words in %0d sets, %0d order words checked, %0d errors",
             words_sent, sets_solved, results_seen, errors);
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
